// ===== src/lkm_pkg.sv =====
// Package for the layered key event mapper: sizes, key and HID codes,
// the command record passed from front to back, and the layer-3 pair table.
// No dependencies.
`default_nettype none
package lkm_pkg;

  localparam int LAYERS         = 4;
  localparam int KEYS_PER_LAYER = 56;
  localparam int KM_DEPTH       = LAYERS * KEYS_PER_LAYER;
  localparam int KM_AW          = $clog2(KM_DEPTH);
  localparam int QDEPTH         = 2;
  localparam int QAW            = $clog2(QDEPTH);

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 72;

  localparam logic       KIND_KEY   = 1'b0;
  localparam logic       KIND_WRITE = 1'b1;

  localparam logic [5:0] KEY_FN      = 6'd40;
  localparam logic [5:0] KEY_PAIR    = 6'd46;
  localparam logic [5:0] KEY_LAYER   = 6'd47;
  localparam logic [5:0] KEY_MOUSE_L = 6'd48;
  localparam logic [5:0] KEY_MOUSE_R = 6'd49;

  localparam logic [14:0] CNT_MAX = 15'd32767;

  localparam logic [7:0] HID_LWIN   = 8'hE3;
  localparam logic [7:0] HID_SPACE  = 8'h2C;
  localparam logic [7:0] HID_LCTRL  = 8'hE0;
  localparam logic [7:0] HID_LSHIFT = 8'hE1;
  localparam logic [7:0] HID_NONE   = 8'h00;

  localparam logic [7:0] MOUSE_BTN_L = 8'd1;
  localparam logic [7:0] MOUSE_BTN_R = 8'd2;

  localparam logic [2:0] ACT_PRESS    = 3'd1;
  localparam logic [2:0] ACT_RELEASE  = 3'd2;
  localparam logic [2:0] ACT_RELALL   = 3'd3;
  localparam logic [2:0] ACT_MPRESS   = 3'd4;
  localparam logic [2:0] ACT_MRELEASE = 3'd5;

  localparam logic [1:0] LAYER_BASE = 2'd0;
  localparam logic [1:0] LAYER_ALT  = 2'd2;
  localparam logic [1:0] LAYER_TOP  = 2'd3;

  typedef struct packed {
    logic        two;
    logic [2:0]  act;
    logic [7:0]  code0;
    logic [7:0]  code1;
    logic [1:0]  layer;
    logic [14:0] key_presses;
    logic [14:0] fn_presses;
    logic [14:0] mouse_clicks;
    logic [5:0]  recent_key;
    logic [1:0]  recent_key_layer;
  } lkm_cmd_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] mod;
    logic [7:0] code;
  } lkm_pair_t;

  function automatic lkm_pair_t pair_lookup(input logic [5:0] key);
    lkm_pair_t r;
    r.hit = 1'b1;
    case (key)
      6'd2:    begin r.mod = HID_LCTRL;  r.code = 8'h2F; end
      6'd3:    begin r.mod = HID_LCTRL;  r.code = 8'h30; end
      6'd9:    begin r.mod = HID_LSHIFT; r.code = 8'h20; end
      6'd10:   begin r.mod = HID_LSHIFT; r.code = 8'h24; end
      6'd11:   begin r.mod = HID_LSHIFT; r.code = 8'h25; end
      6'd13:   begin r.mod = HID_LSHIFT; r.code = 8'h2E; end
      6'd22:   begin r.mod = HID_LSHIFT; r.code = 8'h23; end
      6'd25:   begin r.mod = HID_LCTRL;  r.code = 8'h33; end
      6'd26:   begin r.mod = HID_LCTRL;  r.code = 8'h34; end
      6'd27:   begin r.mod = HID_LCTRL;  r.code = 8'h36; end
      6'd28:   begin r.mod = HID_LCTRL;  r.code = 8'h37; end
      default: begin r.hit = 1'b0; r.mod = HID_NONE; r.code = HID_NONE; end
    endcase
    return r;
  endfunction

  function automatic logic [14:0] sat_inc(input logic [14:0] v);
    return (v >= CNT_MAX) ? CNT_MAX : v + 15'd1;
  endfunction

endpackage
`default_nettype wire

// ===== src/lkm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lkm_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [$clog2(D)-1:0] waddr_i,
  input  wire logic [W-1:0]         wdata_i,
  input  wire logic                 re_i,
  input  wire logic [$clog2(D)-1:0] raddr_i,
  output logic      [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== src/lkm_front.sv =====
// Front end: accepts requests, keeps layer/counters, decodes key events into
// commands, reads/writes the keymap RAM. Depends on lkm_pkg, lkm_ram.
`default_nettype none
module lkm_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_valid_i,
  output logic                               s_ready_o,
  input  wire logic [lkm_pkg::IN_DATA_W-1:0] s_data_i,
  input  wire logic                          s_kind_i,
  output logic                               q_push_o,
  output lkm_pkg::lkm_cmd_t                  q_cmd_o,
  input  wire logic                          q_ready_i
);

  logic [5:0] key;
  logic       pressed;
  logic [1:0] wr_layer;
  logic [5:0] wr_index;
  logic [7:0] wr_code;

  assign key      = s_data_i[5:0];
  assign pressed  = s_data_i[6];
  assign wr_layer = s_data_i[8:7];
  assign wr_index = s_data_i[14:9];
  assign wr_code  = s_data_i[22:15];

  logic [1:0]  layer_q, layer_d;
  logic [14:0] keyp_q, keyp_d, fnp_q, fnp_d, clk_q, clk_d;
  logic [5:0]  rkey_q, rkey_d;
  logic [1:0]  rlay_q, rlay_d;

  logic              s1_valid_q, s1_valid_d;
  logic              s1_ram_q, s1_ram_d;
  lkm_pkg::lkm_cmd_t s1_cmd_q, s1_cmd_d;

  logic                      s_fire, ev_ok, wr_ok, is_mouse;
  logic                      ram_we, ram_re;
  logic [lkm_pkg::KM_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]                ram_rdata;
  logic [2:0]                act;
  lkm_pkg::lkm_pair_t        pair;

  assign q_push_o  = s1_valid_q && q_ready_i;
  assign s_ready_o = !s1_valid_q || q_ready_i;
  assign s_fire    = s_valid_i && s_ready_o;

  assign ev_ok    = (s_kind_i == lkm_pkg::KIND_KEY) && (32'(key) < lkm_pkg::KEYS_PER_LAYER);
  assign wr_ok    = (s_kind_i == lkm_pkg::KIND_WRITE)
                 && (32'(wr_index) < lkm_pkg::KEYS_PER_LAYER)
                 && (32'(wr_layer) < lkm_pkg::LAYERS);
  assign is_mouse = (key == lkm_pkg::KEY_MOUSE_L) || (key == lkm_pkg::KEY_MOUSE_R);
  assign act      = pressed ? lkm_pkg::ACT_PRESS : lkm_pkg::ACT_RELEASE;
  assign pair     = lkm_pkg::pair_lookup(key);

  assign ram_we    = s_fire && wr_ok;
  assign ram_waddr = lkm_pkg::KM_AW'(wr_layer) * lkm_pkg::KM_AW'(lkm_pkg::KEYS_PER_LAYER)
                   + lkm_pkg::KM_AW'(wr_index);
  assign ram_raddr = lkm_pkg::KM_AW'(layer_q) * lkm_pkg::KM_AW'(lkm_pkg::KEYS_PER_LAYER)
                   + lkm_pkg::KM_AW'(key);

  always_comb begin
    layer_d    = layer_q;
    keyp_d     = keyp_q;
    fnp_d      = fnp_q;
    clk_d      = clk_q;
    rkey_d     = rkey_q;
    rlay_d     = rlay_q;
    s1_valid_d = s1_valid_q && !q_push_o;
    s1_ram_d   = s1_ram_q;
    s1_cmd_d   = s1_cmd_q;
    ram_re     = 1'b0;
    if (s_fire && ev_ok) begin
      s1_valid_d     = 1'b1;
      s1_ram_d       = 1'b0;
      s1_cmd_d.two   = 1'b0;
      s1_cmd_d.act   = act;
      s1_cmd_d.code0 = lkm_pkg::HID_NONE;
      s1_cmd_d.code1 = lkm_pkg::HID_NONE;
      if (pressed) begin
        if (!is_mouse) begin
          keyp_d = lkm_pkg::sat_inc(keyp_q);
        end
        rkey_d = key;
        rlay_d = layer_q;
        if (key == lkm_pkg::KEY_FN) begin
          fnp_d = lkm_pkg::sat_inc(fnp_q);
        end
      end
      if (key == lkm_pkg::KEY_LAYER) begin
        if (pressed) begin
          if (layer_q == lkm_pkg::LAYER_BASE) begin
            layer_d = lkm_pkg::LAYER_ALT;
          end else if (layer_q == lkm_pkg::LAYER_ALT) begin
            layer_d = lkm_pkg::LAYER_BASE;
          end
        end
        s1_cmd_d.act = lkm_pkg::ACT_RELALL;
      end else if (is_mouse) begin
        if (pressed) begin
          clk_d = lkm_pkg::sat_inc(clk_q);
        end
        s1_cmd_d.act   = pressed ? lkm_pkg::ACT_MPRESS : lkm_pkg::ACT_MRELEASE;
        s1_cmd_d.code0 = (key == lkm_pkg::KEY_MOUSE_L) ? lkm_pkg::MOUSE_BTN_L
                                                       : lkm_pkg::MOUSE_BTN_R;
      end else if (key == lkm_pkg::KEY_FN) begin
        // FN held selects the odd layer of the current pair
        layer_d      = {layer_q[1], pressed};
        s1_cmd_d.act = lkm_pkg::ACT_RELALL;
      end else if (layer_q[0] && key == lkm_pkg::KEY_PAIR) begin
        s1_cmd_d.two   = 1'b1;
        s1_cmd_d.code0 = lkm_pkg::HID_LWIN;
        s1_cmd_d.code1 = lkm_pkg::HID_SPACE;
      end else if (layer_q == lkm_pkg::LAYER_TOP && pair.hit) begin
        s1_cmd_d.two   = 1'b1;
        s1_cmd_d.code0 = pair.mod;
        s1_cmd_d.code1 = pair.code;
      end else begin
        s1_ram_d = 1'b1;
        ram_re   = 1'b1;
      end
      s1_cmd_d.layer            = layer_d;
      s1_cmd_d.key_presses      = keyp_d;
      s1_cmd_d.fn_presses       = fnp_d;
      s1_cmd_d.mouse_clicks     = clk_d;
      s1_cmd_d.recent_key       = rkey_d;
      s1_cmd_d.recent_key_layer = rlay_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_q    <= '0;
      keyp_q     <= '0;
      fnp_q      <= '0;
      clk_q      <= '0;
      rkey_q     <= '0;
      rlay_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      layer_q    <= layer_d;
      keyp_q     <= keyp_d;
      fnp_q      <= fnp_d;
      clk_q      <= clk_d;
      rkey_q     <= rkey_d;
      rlay_q     <= rlay_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ram_q <= s1_ram_d;
    s1_cmd_q <= s1_cmd_d;
  end

  // keymap lookup result lands while the command waits in s1
  always_comb begin
    q_cmd_o = s1_cmd_q;
    if (s1_ram_q) begin
      q_cmd_o.code0 = ram_rdata;
    end
  end

  lkm_ram #(
    .W(8),
    .D(lkm_pkg::KM_DEPTH)
  ) u_keymap (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(wr_code),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

endmodule
`default_nettype wire

// ===== src/lkm_queue.sv =====
// Short command queue between front and back ends.
// Depends on lkm_pkg.
`default_nettype none
module lkm_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire lkm_pkg::lkm_cmd_t push_cmd_i,
  output logic                   ready_o,
  output logic                   valid_o,
  output lkm_pkg::lkm_cmd_t      head_o,
  input  wire logic              pop_i,
  output logic [lkm_pkg::QAW:0]  count_o
);

  lkm_pkg::lkm_cmd_t          mem_q [lkm_pkg::QDEPTH];
  logic [lkm_pkg::QAW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [lkm_pkg::QAW:0]      cnt_q, cnt_d;
  logic                       do_push, do_pop;

  assign ready_o = cnt_q != (lkm_pkg::QAW+1)'(lkm_pkg::QDEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rptr_q];
  assign count_o = cnt_q;
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (32'(wptr_q) == lkm_pkg::QDEPTH - 1) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (32'(rptr_q) == lkm_pkg::QDEPTH - 1) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule
`default_nettype wire

// ===== src/lkm_back.sv =====
// Back end: expands each queued command into one or two results and holds
// them in the output register. Depends on lkm_pkg.
`default_nettype none
module lkm_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           q_valid_i,
  input  wire lkm_pkg::lkm_cmd_t              q_head_i,
  output logic                                q_pop_o,
  output logic                                m_valid_o,
  input  wire logic                           m_ready_i,
  output logic [lkm_pkg::OUT_DATA_W-1:0]      m_data_o,
  output logic                                m_last_o
);

  logic       out_valid_q, out_valid_d;
  logic       idx_q, idx_d;
  logic       load, fin;
  logic [2:0] act_q;
  logic [7:0] code_q;
  logic       last_q;
  lkm_pkg::lkm_cmd_t stat_q;

  assign load    = q_valid_i && (!out_valid_q || m_ready_i);
  assign fin     = !q_head_i.two || idx_q;
  assign q_pop_o = load && fin;

  always_comb begin
    out_valid_d = out_valid_q && !m_ready_i;
    idx_d       = idx_q;
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = !fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      act_q  <= q_head_i.act;
      code_q <= idx_q ? q_head_i.code1 : q_head_i.code0;
      last_q <= fin;
      stat_q <= q_head_i;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_last_o  = last_q;
  assign m_data_o  = {6'd0, stat_q.recent_key_layer, stat_q.recent_key,
                      stat_q.mouse_clicks, stat_q.fn_presses, stat_q.key_presses,
                      stat_q.layer, code_q, act_q};

endmodule
`default_nettype wire

// ===== src/layered_key_event_mapper.sv =====
// Top level of the layered key event mapper: front end, command queue, back end.
// Depends on lkm_pkg, lkm_front, lkm_queue, lkm_back (and lkm_ram via front).
//
// channel  dir  payload
// s_axis   in   tdata: key_id, pressed, write_layer, write_index, write_code; tuser: kind
// m_axis   out  tdata: action, code, layer, counters, recent key/layer; tlast: last
//
// The output register takes one result per cycle while the receiver is ready:
// one-result events sustain one per cycle, and a two-result event holds its queue
// entry until its second result is loaded. An accepted request waits in s1 while
// its keymap read data lands, then enters the queue and then the output register.
// Reset clears layer, counters and handshake state; the keymap is undefined until
// written and has no clearing pass. Either side may stall; the 2-entry queue
// decouples them.
`default_nettype none
module layered_key_event_mapper (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [5:0] key_id, [6] pressed, [8:7] write_layer, [14:9] write_index,
  // [22:15] write_code, [23] zero
  input  wire logic [lkm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [0] kind
  input  wire logic                               s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [2:0] action, [10:3] code, [12:11] layer, [27:13] key_presses,
  // [42:28] fn_presses, [57:43] mouse_clicks, [63:58] recent_key,
  // [65:64] recent_key_layer, [71:66] zero
  output logic [lkm_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
  output logic                                    m_axis_tlast
);

  logic                  q_push, q_ready, q_valid, q_pop;
  lkm_pkg::lkm_cmd_t     q_in, q_head;
  logic [lkm_pkg::QAW:0] q_count;

  lkm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_ready_o(s_axis_tready),
    .s_data_i (s_axis_tdata),
    .s_kind_i (s_axis_tuser),
    .q_push_o (q_push),
    .q_cmd_o  (q_in),
    .q_ready_i(q_ready)
  );

  lkm_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_cmd_i(q_in),
    .ready_o   (q_ready),
    .valid_o   (q_valid),
    .head_o    (q_head),
    .pop_i     (q_pop),
    .count_o   (q_count)
  );

  lkm_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_head_i (q_head),
    .q_pop_o  (q_pop),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .m_data_o (m_axis_tdata),
    .m_last_o (m_axis_tlast)
  );

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(q_count) <= lkm_pkg::QDEPTH)
    else $error("command queue over capacity");

  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("second result of a pair not ready");

  a_pair_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |->
      (m_axis_tdata[2:0] == lkm_pkg::ACT_PRESS || m_axis_tdata[2:0] == lkm_pkg::ACT_RELEASE))
    else $error("paired result with bad action");

  a_mouse_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[2:0] == lkm_pkg::ACT_MPRESS
                      || m_axis_tdata[2:0] == lkm_pkg::ACT_MRELEASE) |->
      (m_axis_tdata[10:3] == lkm_pkg::MOUSE_BTN_L || m_axis_tdata[10:3] == lkm_pkg::MOUSE_BTN_R))
    else $error("mouse result with bad button code");

endmodule
`default_nettype wire

// ===== sim/key_action_checker.sv =====
// Checker for the layered key event mapper: watches both stream channels, predicts
// the HID actions of every accepted request and compares them field by field.
// Depends on lkm_pkg for sizes, key ids, action and HID codes.
module key_action_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  // [5:0] key_id, [6] pressed, [8:7] write_layer, [14:9] write_index,
  // [22:15] write_code, [23] zero
  input  logic [lkm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [0] kind
  input  logic                           s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [2:0] action, [10:3] code, [12:11] layer, [27:13] key_presses,
  // [42:28] fn_presses, [57:43] mouse_clicks, [63:58] recent_key,
  // [65:64] recent_key_layer, [71:66] zero
  input  logic [lkm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           m_axis_tlast,
  output int                             fail_count_o,
  output int                             pending_o
);

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  code;
    logic        last;
    logic [1:0]  layer;
    logic [14:0] key_presses;
    logic [14:0] fn_presses;
    logic [14:0] mouse_clicks;
    logic [5:0]  recent_key;
    logic [1:0]  recent_key_layer;
  } hid_action_t;

  hid_action_t expected_actions[$];
  hid_action_t want;
  hid_action_t seen;
  int          fails;

  logic [1:0]  cur_layer;
  logic [14:0] press_count;
  logic [14:0] fn_count;
  logic [14:0] click_count;
  logic [5:0]  last_key;
  logic [1:0]  last_key_layer;
  logic [7:0]  keymap [lkm_pkg::LAYERS][lkm_pkg::KEYS_PER_LAYER];

  // layer-3 modifier/key pairs, indexed by key id; a zero modifier means no pair
  logic [7:0]  pair_mod  [64];
  logic [7:0]  pair_code [64];

  initial begin
    for (int k = 0; k < 64; k++) begin
      pair_mod[k]  = lkm_pkg::HID_NONE;
      pair_code[k] = lkm_pkg::HID_NONE;
    end
    pair_mod[2]  = lkm_pkg::HID_LCTRL;  pair_code[2]  = 8'h2F;
    pair_mod[3]  = lkm_pkg::HID_LCTRL;  pair_code[3]  = 8'h30;
    pair_mod[9]  = lkm_pkg::HID_LSHIFT; pair_code[9]  = 8'h20;
    pair_mod[10] = lkm_pkg::HID_LSHIFT; pair_code[10] = 8'h24;
    pair_mod[11] = lkm_pkg::HID_LSHIFT; pair_code[11] = 8'h25;
    pair_mod[13] = lkm_pkg::HID_LSHIFT; pair_code[13] = 8'h2E;
    pair_mod[22] = lkm_pkg::HID_LSHIFT; pair_code[22] = 8'h23;
    pair_mod[25] = lkm_pkg::HID_LCTRL;  pair_code[25] = 8'h33;
    pair_mod[26] = lkm_pkg::HID_LCTRL;  pair_code[26] = 8'h34;
    pair_mod[27] = lkm_pkg::HID_LCTRL;  pair_code[27] = 8'h36;
    pair_mod[28] = lkm_pkg::HID_LCTRL;  pair_code[28] = 8'h37;
  end

  task automatic predict_actions(input logic [lkm_pkg::IN_DATA_W-1:0] d, input logic kind);
    logic [5:0]  key;
    logic        press;
    logic [2:0]  act;
    logic [2:0]  acts [2];
    logic [7:0]  codes [2];
    logic [1:0]  base;
    int          n;
    hid_action_t r;
    key   = d[5:0];
    press = d[6];
    act   = press ? lkm_pkg::ACT_PRESS : lkm_pkg::ACT_RELEASE;
    n     = 0;
    if (kind == lkm_pkg::KIND_WRITE) begin
      if (d[14:9] < lkm_pkg::KEYS_PER_LAYER && d[8:7] < lkm_pkg::LAYERS) begin
        keymap[d[8:7]][d[14:9]] = d[22:15];
      end
    end else if (key < lkm_pkg::KEYS_PER_LAYER) begin
      if (press) begin
        if (key != lkm_pkg::KEY_MOUSE_L && key != lkm_pkg::KEY_MOUSE_R
            && press_count != lkm_pkg::CNT_MAX) begin
          press_count++;
        end
        last_key       = key;
        last_key_layer = cur_layer;
        if (key == lkm_pkg::KEY_FN && fn_count != lkm_pkg::CNT_MAX) begin
          fn_count++;
        end
      end
      if (key == lkm_pkg::KEY_LAYER) begin
        if (press && cur_layer == lkm_pkg::LAYER_BASE) begin
          cur_layer = lkm_pkg::LAYER_ALT;
        end else if (press && cur_layer == lkm_pkg::LAYER_ALT) begin
          cur_layer = lkm_pkg::LAYER_BASE;
        end
        acts[0]  = lkm_pkg::ACT_RELALL;
        codes[0] = lkm_pkg::HID_NONE;
        n        = 1;
      end else if (key == lkm_pkg::KEY_MOUSE_L || key == lkm_pkg::KEY_MOUSE_R) begin
        if (press && click_count != lkm_pkg::CNT_MAX) begin
          click_count++;
        end
        acts[0]  = press ? lkm_pkg::ACT_MPRESS : lkm_pkg::ACT_MRELEASE;
        codes[0] = (key == lkm_pkg::KEY_MOUSE_L) ? lkm_pkg::MOUSE_BTN_L
                                                 : lkm_pkg::MOUSE_BTN_R;
        n        = 1;
      end else if (key == lkm_pkg::KEY_FN) begin
        base      = (cur_layer >= lkm_pkg::LAYER_ALT) ? lkm_pkg::LAYER_ALT
                                                      : lkm_pkg::LAYER_BASE;
        cur_layer = press ? base + 2'd1 : base;
        acts[0]   = lkm_pkg::ACT_RELALL;
        codes[0]  = lkm_pkg::HID_NONE;
        n         = 1;
      end else if (cur_layer[0] && key == lkm_pkg::KEY_PAIR) begin
        acts[0]  = act;
        codes[0] = lkm_pkg::HID_LWIN;
        acts[1]  = act;
        codes[1] = lkm_pkg::HID_SPACE;
        n        = 2;
      end else if (cur_layer == lkm_pkg::LAYER_TOP && pair_mod[key] != lkm_pkg::HID_NONE) begin
        acts[0]  = act;
        codes[0] = pair_mod[key];
        acts[1]  = act;
        codes[1] = pair_code[key];
        n        = 2;
      end else begin
        acts[0]  = act;
        codes[0] = keymap[cur_layer][key];
        n        = 1;
      end
      for (int i = 0; i < n; i++) begin
        r.action           = acts[i];
        r.code             = codes[i];
        r.last             = (i == n - 1);
        r.layer            = cur_layer;
        r.key_presses      = press_count;
        r.fn_presses       = fn_count;
        r.mouse_clicks     = click_count;
        r.recent_key       = last_key;
        r.recent_key_layer = last_key_layer;
        expected_actions.push_back(r);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [14:0] exp_v,
                             input logic [14:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_layer      = lkm_pkg::LAYER_BASE;
      press_count    = '0;
      fn_count       = '0;
      click_count    = '0;
      last_key       = '0;
      last_key_layer = lkm_pkg::LAYER_BASE;
      fails          = 0;
      expected_actions.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_actions(s_axis_tdata, s_axis_tuser);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen.action           = m_axis_tdata[2:0];
        seen.code             = m_axis_tdata[10:3];
        seen.last             = m_axis_tlast;
        seen.layer            = m_axis_tdata[12:11];
        seen.key_presses      = m_axis_tdata[27:13];
        seen.fn_presses       = m_axis_tdata[42:28];
        seen.mouse_clicks     = m_axis_tdata[57:43];
        seen.recent_key       = m_axis_tdata[63:58];
        seen.recent_key_layer = m_axis_tdata[65:64];
        if (expected_actions.size() == 0) begin
          $display("%0t: unexpected action, expected none, actual %h", $time, seen);
          fails++;
        end else begin
          want = expected_actions.pop_front();
          check_field("action", 15'(want.action), 15'(seen.action));
          check_field("code", 15'(want.code), 15'(seen.code));
          check_field("last", 15'(want.last), 15'(seen.last));
          check_field("layer", 15'(want.layer), 15'(seen.layer));
          check_field("key_presses", want.key_presses, seen.key_presses);
          check_field("fn_presses", want.fn_presses, seen.fn_presses);
          check_field("mouse_clicks", want.mouse_clicks, seen.mouse_clicks);
          check_field("recent_key", 15'(want.recent_key), 15'(seen.recent_key));
          check_field("recent_key_layer", 15'(want.recent_key_layer),
                      15'(seen.recent_key_layer));
        end
      end
      fail_count_o <= fails;
      pending_o    <= expected_actions.size();
    end
  end

endmodule

// ===== sim/tb_layered_key_event_mapper.sv =====
// Testbench top for the layered key event mapper: clock, reset, request stimulus,
// output stall patterns, idle watchdog and the final verdict.
// Depends on lkm_pkg, layered_key_event_mapper and key_action_checker.
module tb_layered_key_event_mapper;

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_LEN   = 300;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [lkm_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic                           s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [lkm_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           m_axis_tlast;
  int                             fail_count;
  int                             pending;

  int burst_left;
  bit brisk;
  int hold_reqs;
  int idle_cycles;

  layered_key_event_mapper uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  key_action_checker action_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles = 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("layered_key_event_mapper verification failed");
        $finish;
      end
    end
  end

  // receiver: stall modes that change now and then, plus long hold-offs on request
  initial begin
    int rx_mode;
    int mode_left;
    int hold_left;
    int holds_done;
    int phase;
    rx_mode       = 0;
    mode_left     = 0;
    hold_left     = 0;
    holds_done    = 0;
    phase         = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      phase++;
      if (hold_reqs != holds_done) begin
        holds_done = hold_reqs;
        hold_left  = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (brisk) begin
        m_axis_tready <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (rx_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          2:       m_axis_tready <= ((phase % 5) < 2);
          default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  task automatic send_req(input logic kind, input logic [5:0] key, input logic pressed,
                          input logic [1:0] wl, input logic [5:0] wi, input logic [7:0] wc);
    int gap;
    if (burst_left == 0 && !brisk) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {1'b0, wc, wi, wl, pressed, key};
    do @(posedge clk_i); while (!s_axis_tready);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic key_event(input logic [5:0] key, input logic pressed);
    send_req(lkm_pkg::KIND_KEY, key, pressed, 2'($urandom_range(0, 3)),
             6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
  endtask

  task automatic map_write(input logic [1:0] wl, input logic [5:0] wi, input logic [7:0] wc);
    send_req(lkm_pkg::KIND_WRITE, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
             wl, wi, wc);
  endtask

  function automatic logic [5:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return lkm_pkg::KEY_FN;
    if (r < 25) return lkm_pkg::KEY_LAYER;
    if (r < 35) return $urandom_range(0, 1) ? lkm_pkg::KEY_MOUSE_L : lkm_pkg::KEY_MOUSE_R;
    if (r < 45) return lkm_pkg::KEY_PAIR;
    if (r < 70) begin
      case ($urandom_range(0, 10))
        0:       return 6'd2;
        1:       return 6'd3;
        2:       return 6'd9;
        3:       return 6'd10;
        4:       return 6'd11;
        5:       return 6'd13;
        6:       return 6'd22;
        7:       return 6'd25;
        8:       return 6'd26;
        9:       return 6'd27;
        default: return 6'd28;
      endcase
    end
    return 6'($urandom_range(0, lkm_pkg::KEYS_PER_LAYER - 1));
  endfunction

  task automatic random_traffic(input int count);
    int done_items;
    int r;
    logic [5:0] idx;
    done_items = 0;
    while (done_items < count) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        idx = 6'($urandom_range(0, 63));
        map_write(2'($urandom_range(0, 3)), idx, 8'($urandom_range(0, 255)));
        if (idx < lkm_pkg::KEYS_PER_LAYER) done_items++;
      end else if (r < 12) begin
        key_event(6'($urandom_range(lkm_pkg::KEYS_PER_LAYER, 63)), 1'($urandom_range(0, 1)));
      end else begin
        key_event(pick_key(), 1'($urandom_range(0, 1)));
        done_items++;
      end
    end
  endtask

  initial begin
    logic [5:0] btn;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = lkm_pkg::KIND_KEY;
    burst_left    = 0;
    brisk         = 1'b0;
    hold_reqs     = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the whole keymap so that no key event reads an empty entry
    for (int l = 0; l < lkm_pkg::LAYERS; l++) begin
      for (int k = 0; k < lkm_pkg::KEYS_PER_LAYER; k++) begin
        map_write(2'(l), 6'(k), 8'($urandom_range(0, 255)));
      end
    end

    // directed: extremes, layer moves, pairs, mouse, ignored ids and writes
    map_write(2'd3, 6'd55, 8'hFF);
    map_write(2'd0, 6'd0, 8'h00);
    map_write(2'd1, 6'd63, 8'hAA);
    map_write(2'd2, 6'd56, 8'h55);
    key_event(6'd0, 1'b1);
    key_event(6'd0, 1'b0);
    key_event(6'd55, 1'b1);
    key_event(6'd63, 1'b1);
    key_event(6'd56, 1'b0);
    key_event(lkm_pkg::KEY_FN, 1'b1);
    key_event(lkm_pkg::KEY_PAIR, 1'b1);
    key_event(lkm_pkg::KEY_PAIR, 1'b0);
    key_event(lkm_pkg::KEY_LAYER, 1'b1);
    key_event(lkm_pkg::KEY_FN, 1'b0);
    key_event(lkm_pkg::KEY_LAYER, 1'b1);
    key_event(lkm_pkg::KEY_LAYER, 1'b0);
    key_event(lkm_pkg::KEY_FN, 1'b1);
    key_event(6'd2, 1'b1);
    key_event(6'd28, 1'b0);
    key_event(lkm_pkg::KEY_PAIR, 1'b1);
    key_event(6'd55, 1'b1);
    key_event(lkm_pkg::KEY_LAYER, 1'b1);
    key_event(lkm_pkg::KEY_FN, 1'b0);
    key_event(lkm_pkg::KEY_MOUSE_L, 1'b1);
    key_event(lkm_pkg::KEY_MOUSE_L, 1'b0);
    key_event(lkm_pkg::KEY_MOUSE_R, 1'b1);
    key_event(lkm_pkg::KEY_MOUSE_R, 1'b0);
    key_event(lkm_pkg::KEY_LAYER, 1'b1);

    // random traffic, each half opened by a long output hold-off
    hold_reqs++;
    random_traffic(60);
    hold_reqs++;
    random_traffic(60);

    // a short stretch at full rate with the receiver always ready
    brisk = 1'b1;
    repeat (4) begin
      btn = $urandom_range(0, 1) ? lkm_pkg::KEY_MOUSE_L : lkm_pkg::KEY_MOUSE_R;
      key_event(lkm_pkg::KEY_FN, 1'b1);
      key_event(btn, 1'b1);
      key_event(btn, 1'b0);
      key_event(lkm_pkg::KEY_FN, 1'b0);
    end
    brisk = 1'b0;
    random_traffic(10);

    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("layered_key_event_mapper verification clean");
    end else begin
      $display("layered_key_event_mapper verification failed");
    end
    $finish;
  end

endmodule
